// ===== hw/rtl/minv_pkg.sv =====
// shared types and constants for the 64-bit modular inverse block
`timescale 1ns / 1ps
package minv_pkg;

	// datapath width, 8 to 64
	localparam int WORD_BITS  = 64;
	localparam int SHIFT_BITS = $clog2(WORD_BITS);

	// fixed field widths on the ports
	localparam int FIELD_BITS   = 64;
	localparam int IN_DATA_BITS = 2 * FIELD_BITS;

	localparam logic [WORD_BITS-1:0] W_ZERO = '0;
	localparam logic [WORD_BITS-1:0] W_ONE  = WORD_BITS'(1);
	localparam logic [WORD_BITS-1:0] W_TWO  = WORD_BITS'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_SUB,
		ST_SWAP,
		ST_DONE
	} minv_state_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] inverse;
		logic                 invalid;
	} minv_res_t;

endpackage

// ===== hw/rtl/minv_core.sv =====
// euclid sequencer with one shared shift-subtract-accumulate unit
`timescale 1ns / 1ps
module minv_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [minv_pkg::WORD_BITS-1:0] value,
	input  logic [minv_pkg::WORD_BITS-1:0] modulus,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ack,
	output minv_pkg::minv_res_t           res
);
	import minv_pkg::*;

	minv_state_t state_q, state_d;

	logic [WORD_BITS-1:0]  dvd_q;   // running remainder
	logic [WORD_BITS-1:0]  dvs_q;   // current divisor
	logic [WORD_BITS-1:0]  dsh_q;   // divisor aligned to the quotient bit
	logic [WORD_BITS-1:0]  csh_q;   // convergent aligned to the quotient bit
	logic [WORD_BITS-1:0]  cur_q;
	logic [WORD_BITS-1:0]  prev_q;  // also accumulates q*cur + prev
	logic [WORD_BITS-1:0]  mod_q;
	logic                  odd_q;
	logic [SHIFT_BITS-1:0] k_q;
	minv_res_t             res_q;

	logic                 can_dbl;
	logic                 ge;
	logic [WORD_BITS-1:0] diff;
	logic [WORD_BITS-1:0] acc_sum;
	logic                 k_zero;
	logic                 rem_gt1;
	logic                 sp_any;
	minv_res_t            sp_res;

	assign can_dbl = !dsh_q[WORD_BITS-1] && ({dsh_q[WORD_BITS-2:0], 1'b0} <= dvd_q);
	assign ge      = dvd_q >= dsh_q;
	assign diff    = dvd_q - dsh_q;
	assign acc_sum = prev_q + csh_q;
	assign k_zero  = (k_q == '0);
	assign rem_gt1 = (dvd_q[WORD_BITS-1:1] != '0);

	// cases settled without running the recurrence
	always_comb begin
		sp_any = 1'b1;
		sp_res = '{inverse: W_ZERO, invalid: 1'b0};
		if (value >= modulus) begin
			sp_res.invalid = 1'b1;
		end else if (value[WORD_BITS-1:1] == '0) begin
			sp_res.inverse = value;
		end else if (value == W_TWO) begin
			if (!modulus[0]) begin
				sp_res.invalid = 1'b1;
			end else begin
				sp_res.inverse = (modulus >> 1) + W_ONE;
			end
		end else begin
			sp_any = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = sp_any ? ST_DONE : ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				if (!can_dbl) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				if (k_zero) begin
					state_d = ST_SWAP;
				end
			end
			ST_SWAP: begin
				state_d = rem_gt1 ? ST_ALIGN : ST_DONE;
			end
			ST_DONE: begin
				if (res_ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		idle      = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_q  <= sp_res;
					mod_q  <= modulus;
					dvd_q  <= modulus;
					dvs_q  <= value;
					dsh_q  <= value;
					csh_q  <= W_ONE;
					cur_q  <= W_ONE;
					prev_q <= W_ZERO;
					odd_q  <= 1'b1;
					k_q    <= '0;
				end
			end
			ST_ALIGN: begin
				if (can_dbl) begin
					dsh_q <= {dsh_q[WORD_BITS-2:0], 1'b0};
					csh_q <= {csh_q[WORD_BITS-2:0], 1'b0};
					k_q   <= k_q + SHIFT_BITS'(1);
				end
			end
			ST_SUB: begin
				if (ge) begin
					dvd_q  <= diff;
					prev_q <= acc_sum;
				end
				if (!k_zero) begin
					dsh_q <= dsh_q >> 1;
					csh_q <= csh_q >> 1;
					k_q   <= k_q - SHIFT_BITS'(1);
				end
			end
			ST_SWAP: begin
				// remainder becomes the next divisor, accumulator the next convergent
				dvd_q  <= dvs_q;
				dvs_q  <= dvd_q;
				dsh_q  <= dvd_q;
				cur_q  <= prev_q;
				csh_q  <= prev_q;
				prev_q <= cur_q;
				odd_q  <= !odd_q;
				k_q    <= '0;
				if (dvd_q == W_ZERO) begin
					res_q <= '{inverse: W_ZERO, invalid: 1'b1};
				end else begin
					res_q <= '{inverse: (odd_q ? (mod_q - prev_q) : prev_q), invalid: 1'b0};
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/modular_inverse_64_top.sv =====
// Modular inverse of a 64-bit value by the extended Euclidean recurrence. Each
// transaction on the input stream carries value and modulus and yields one
// transaction on the output stream with the inverse and an invalid flag
// (value not below modulus, or not coprime to it; inverse is then 0). Values 0
// and 1 return themselves with the flag clear, and 2 returns (modulus+1)/2,
// without running the recurrence. Other values run one shift-subtract-accumulate
// unit under a sequencer: each Euclid step shifts the divisor up to the quotient's
// top bit, shifts it back down subtracting wherever it fits, and then rotates
// the registers. Input is taken only while the sequencer is idle; a finished
// result sits in an output register so the next item may start while it waits
// to be taken.
`timescale 1ns / 1ps
module modular_inverse_64_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// value [63:0], modulus [127:64]
	input  logic [minv_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// inverse [63:0]
	output logic [minv_pkg::FIELD_BITS-1:0]   m_axis_tdata,
	// invalid [0]
	output logic                              m_axis_tuser
);
	import minv_pkg::*;

	logic                 core_idle;
	logic                 core_start;
	logic                 core_valid;
	logic                 core_ack;
	minv_res_t            core_res;
	logic [WORD_BITS-1:0] value;
	logic [WORD_BITS-1:0] modulus;

	logic      out_valid_q;
	minv_res_t out_q;

	assign value      = s_axis_tdata[WORD_BITS-1:0];
	assign modulus    = s_axis_tdata[FIELD_BITS +: WORD_BITS];
	assign s_axis_tready = core_idle;
	assign core_start = s_axis_tvalid && core_idle;
	assign core_ack   = core_valid && (!out_valid_q || m_axis_tready);

	minv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (core_start),
		.value     (value),
		.modulus   (modulus),
		.idle      (core_idle),
		.res_valid (core_valid),
		.res_ack   (core_ack),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ack) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = FIELD_BITS'(out_q.inverse);
	assign m_axis_tuser  = out_q.invalid;

endmodule
